// File: rtl/core/url_percent_encoder_macros.svh
// Assertion macros shared by the percent-encoder RTL.
`ifndef URL_PERCENT_ENCODER_MACROS_SVH
`define URL_PERCENT_ENCODER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define UPE_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("upe: implication check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define UPE_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("upe: next-cycle check failed");
`else
`define UPE_ASSERT_IMP(label, clk, rstn, ante, cons)
`define UPE_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/upe_pkg.sv
// Shared types, constants and character helpers of the percent encoder.
package upe_pkg;

    // Field widths and queue depth.
    localparam int LIMIT_W        = 16;
    localparam int LEN_W          = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int QDEPTH         = 4;

    // Character codes.
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_USCR  = 8'h5F;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [3:0] NIB_MASK = 4'hF;

    // Lookahead state of the front end.
    typedef enum logic [1:0] {
        LK_NONE,
        LK_PCT,
        LK_HEX
    } t_look;

    // One output group: a byte sent as is, or expanded to three bytes.
    typedef struct packed {
        logic [7:0] data;
        logic       wide;
    } t_tok;

    // Work for one accepted input: one to three groups.
    typedef struct packed {
        logic [1:0]     ntok;
        t_tok [2:0]     tok;
        logic           last;
    } t_entry;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
               (c >= "a" && c <= "f");
    endfunction

    function automatic logic passes(input logic [7:0] c, input logic keep_slash);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == CH_DASH || c == CH_DOT ||
               c == CH_USCR || c == CH_TILDE || (c == CH_SLASH && keep_slash);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
    endfunction

endpackage

// File: rtl/core/url_percent_encoder.sv
// Top level of the streaming URL percent encoder with its register port.
//
// Channel   Dir  Transaction                 Fields (low bit first)
// s_axis    in   one raw byte                tdata: in_byte; tlast: in_last
// m_axis    out  one encoded byte            tdata: out_byte, total_length;
//                                            tuser: run_last, overflow; tlast: string_last
// apb       in   register write or read      0x0 keep_slash, 0x4 output_limit
//
// The front end takes one input byte per cycle while its four-entry queue has room.
// The back end emits one output byte per cycle while work is queued and the receiver is
// ready, so an input byte yields zero to seven output bytes (zero while held as lookahead,
// three for an encoded byte); output bandwidth sets the sustained rate.
// Reset is synchronous and active low; no clearing pass follows it.
// A stalled output holds in the output register while the front end keeps filling the queue.
`include "url_percent_encoder_macros.svh"

module url_percent_encoder #(
    parameter int COUNT_BITS = upe_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] total_length
    output logic [1:0]  m_axis_tuser,   // [0] run_last, [1] overflow
    output logic        m_axis_tlast,
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                        r_keep_slash;
    logic [upe_pkg::LIMIT_W-1:0] r_out_limit;
    logic                        w_cfg_wr;
    logic                        w_push, w_q_full, w_q_valid, w_pop;
    upe_pkg::t_entry             w_entry, w_head;
    logic [7:0]                  w_out_byte;
    logic                        w_run_last, w_str_last, w_ovf;
    logic [upe_pkg::LEN_W-1:0]   w_total;

    // Configuration registers.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_slash <= 1'b1;
            r_out_limit  <= '0;
        end else if (w_cfg_wr) begin
            if (paddr[2]) begin
                r_out_limit <= pwdata[upe_pkg::LIMIT_W-1:0];
            end else begin
                r_keep_slash <= pwdata[0];
            end
        end
    end

    assign prdata = paddr[2] ? {{(32 - upe_pkg::LIMIT_W){1'b0}}, r_out_limit}
                             : {31'b0, r_keep_slash};

    // Front end.
    upe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_data       (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .i_keep_slash (r_keep_slash),
        .i_q_full     (w_q_full),
        .o_ready      (s_axis_tready),
        .o_push       (w_push),
        .o_entry      (w_entry)
    );

    // Queue between the two halves.
    upe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_head  (w_head)
    );

    // Back end.
    upe_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_head        (w_head),
        .i_limit       (r_out_limit),
        .i_out_ready   (m_axis_tready),
        .o_pop         (w_pop),
        .o_out_valid   (m_axis_tvalid),
        .o_out_byte    (w_out_byte),
        .o_run_last    (w_run_last),
        .o_string_last (w_str_last),
        .o_overflow    (w_ovf),
        .o_total       (w_total)
    );

    assign m_axis_tdata = {w_total, w_out_byte};
    assign m_axis_tuser = {w_ovf, w_run_last};
    assign m_axis_tlast = w_str_last;

    // The last byte of a string always produces work for the back end.
    `UPE_ASSERT_IMP(a_last_pushes, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, w_push)
    // Pushed work is visible at the queue head on the next cycle.
    `UPE_ASSERT_NXT(a_push_visible, i_clk, i_rst_n, w_push, w_q_valid)
    // The end of a string is always also the end of a run.
    `UPE_ASSERT_IMP(a_str_run, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser[0])
    // Suppressed output carries a zero byte.
    `UPE_ASSERT_IMP(a_ovf_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata[7:0] == 8'h00)

endmodule

// File: rtl/core/upe_front.sv
// Front end: accepts input bytes, tracks the escape lookahead, builds group lists.
module upe_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_data,
    input  logic            i_last,
    input  logic            i_keep_slash,
    input  logic            i_q_full,
    output logic            o_ready,
    output logic            o_push,
    output upe_pkg::t_entry o_entry
);

    upe_pkg::t_look r_stage, n_stage;
    logic [7:0]     r_held, n_held;
    logic           w_acc;
    logic           w_hex;
    logic           w_holds;
    upe_pkg::t_tok  w_tok_c;

    assign o_ready = !i_q_full;
    assign w_acc   = i_valid && o_ready;
    assign w_hex   = upe_pkg::is_hex(i_data);
    // A fresh '%' that is not the last byte opens a new lookahead.
    assign w_holds = (i_data == upe_pkg::CH_PCT) && !i_last;
    assign w_tok_c = '{data: i_data, wide: !upe_pkg::passes(i_data, i_keep_slash)};

    // Next lookahead state.
    always_comb begin
        n_stage = r_stage;
        n_held  = r_held;
        if (w_acc) begin
            if (i_last) begin
                n_stage = upe_pkg::LK_NONE;
            end else begin
                unique case (r_stage)
                    upe_pkg::LK_NONE: begin
                        n_stage = w_holds ? upe_pkg::LK_PCT : upe_pkg::LK_NONE;
                    end
                    upe_pkg::LK_PCT: begin
                        if (w_hex) begin
                            n_stage = upe_pkg::LK_HEX;
                            n_held  = i_data;
                        end else begin
                            n_stage = w_holds ? upe_pkg::LK_PCT : upe_pkg::LK_NONE;
                        end
                    end
                    upe_pkg::LK_HEX: begin
                        n_stage = (!w_hex && w_holds) ? upe_pkg::LK_PCT
                                                      : upe_pkg::LK_NONE;
                    end
                    default: begin
                        n_stage = upe_pkg::LK_NONE;
                    end
                endcase
            end
        end
    end

    // Group list for the accepted byte.
    always_comb begin
        o_entry      = '0;
        o_entry.last = i_last;
        o_push       = 1'b0;
        unique case (r_stage)
            upe_pkg::LK_NONE: begin
                o_push         = w_acc && !w_holds;
                o_entry.ntok   = 2'd1;
                o_entry.tok[0] = w_tok_c;
            end
            upe_pkg::LK_PCT: begin
                o_push         = w_acc && !(w_hex && !i_last);
                o_entry.tok[0] = '{data: upe_pkg::CH_PCT, wide: 1'b1};
                o_entry.tok[1] = w_tok_c;
                o_entry.ntok   = w_holds ? 2'd1 : 2'd2;
            end
            upe_pkg::LK_HEX: begin
                o_push         = w_acc;
                o_entry.tok[1] = '{data: r_held, wide: 1'b0};
                if (w_hex) begin
                    // Existing escape passes through literally.
                    o_entry.tok[0] = '{data: upe_pkg::CH_PCT, wide: 1'b0};
                    o_entry.tok[2] = '{data: i_data, wide: 1'b0};
                    o_entry.ntok   = 2'd3;
                end else begin
                    o_entry.tok[0] = '{data: upe_pkg::CH_PCT, wide: 1'b1};
                    o_entry.tok[2] = w_tok_c;
                    o_entry.ntok   = w_holds ? 2'd2 : 2'd3;
                end
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= upe_pkg::LK_NONE;
        end else begin
            r_stage <= n_stage;
        end
        r_held <= n_held;
    end

endmodule

// File: rtl/core/upe_queue.sv
// Short queue of group lists between the front end and the back end.
module upe_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  upe_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output upe_pkg::t_entry o_head
);

    localparam int PW = $clog2(upe_pkg::QDEPTH);
    localparam int CW = $clog2(upe_pkg::QDEPTH + 1);

    upe_pkg::t_entry r_mem [upe_pkg::QDEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;
    logic            w_pop;

    assign o_full  = (r_cnt == CW'(upe_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign w_pop   = i_pop && o_valid;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(upe_pkg::QDEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(upe_pkg::QDEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && w_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// File: rtl/core/upe_back.sv
// Back end: expands groups into output bytes, counts length, applies the limit.
module upe_back #(
    parameter int COUNT_BITS = upe_pkg::COUNT_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  upe_pkg::t_entry            i_head,
    input  logic [upe_pkg::LIMIT_W-1:0] i_limit,
    input  logic                       i_out_ready,
    output logic                       o_pop,
    output logic                       o_out_valid,
    output logic [7:0]                 o_out_byte,
    output logic                       o_run_last,
    output logic                       o_string_last,
    output logic                       o_overflow,
    output logic [upe_pkg::LEN_W-1:0]  o_total
);

    localparam int SW = ((COUNT_BITS > upe_pkg::LIMIT_W) ? COUNT_BITS : upe_pkg::LIMIT_W) + 1;
    localparam int TW = (COUNT_BITS > upe_pkg::LEN_W) ? COUNT_BITS : upe_pkg::LEN_W;

    logic [1:0]            r_tok_idx, r_byte_idx;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_ovf;
    logic                  r_out_valid;
    logic [7:0]            r_out_byte;
    logic                  r_run_last, r_str_last, r_out_ovf;
    logic [upe_pkg::LEN_W-1:0] r_total;

    upe_pkg::t_tok         w_tok;
    logic                  w_adv;
    logic [1:0]            w_size;
    logic [SW-1:0]         w_sum;
    logic                  w_trip, w_ovf_now;
    logic [7:0]            w_byte;
    logic                  w_tok_end, w_entry_end;
    logic [COUNT_BITS-1:0] w_cnt_inc;
    logic [TW-1:0]         w_cnt_ext;

    assign w_tok  = i_head.tok[r_tok_idx];
    assign w_adv  = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_pop  = w_adv && w_entry_end;
    assign w_size = w_tok.wide ? 2'd3 : 2'd1;

    // Limit check on the first byte of each group.
    assign w_sum     = SW'(r_count) + SW'(w_size);
    assign w_trip    = (r_byte_idx == 2'd0) && !r_ovf && (i_limit != '0) &&
                       (w_sum > SW'(i_limit));
    assign w_ovf_now = r_ovf || w_trip;

    // Byte selection within a group.
    always_comb begin
        if (!w_tok.wide) begin
            w_byte = w_tok.data;
        end else begin
            unique case (r_byte_idx)
                2'd0:    w_byte = upe_pkg::CH_PCT;
                2'd1:    w_byte = upe_pkg::hex_char(w_tok.data[7:4] & upe_pkg::NIB_MASK);
                default: w_byte = upe_pkg::hex_char(w_tok.data[3:0] & upe_pkg::NIB_MASK);
            endcase
        end
    end

    assign w_tok_end   = !w_tok.wide || (r_byte_idx == 2'd2);
    assign w_entry_end = w_tok_end && ((r_tok_idx + 2'd1) == i_head.ntok);

    // Saturating length count.
    assign w_cnt_inc = (r_count == '1) ? r_count : r_count + COUNT_BITS'(1);
    assign w_cnt_ext = TW'(w_cnt_inc);

    // Sequencing and string state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_idx   <= '0;
            r_byte_idx  <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= 1'b1;
                if (w_entry_end) begin
                    r_tok_idx  <= '0;
                    r_byte_idx <= '0;
                    r_count    <= i_head.last ? '0 : w_cnt_inc;
                    r_ovf      <= i_head.last ? 1'b0 : w_ovf_now;
                end else begin
                    r_count <= w_cnt_inc;
                    r_ovf   <= w_ovf_now;
                    if (w_tok_end) begin
                        r_tok_idx  <= r_tok_idx + 2'd1;
                        r_byte_idx <= '0;
                    end else begin
                        r_byte_idx <= r_byte_idx + 2'd1;
                    end
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_byte <= w_ovf_now ? 8'h00 : w_byte;
            r_run_last <= w_entry_end;
            r_str_last <= w_entry_end && i_head.last;
            r_out_ovf  <= w_ovf_now;
            r_total    <= w_cnt_ext[upe_pkg::LEN_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_run_last    = r_run_last;
    assign o_string_last = r_str_last;
    assign o_overflow    = r_out_ovf;
    assign o_total       = r_total;

endmodule

// File: sim/url_percent_encoder_tb.sv
// Self-checking testbench for the streaming URL percent encoder.
`timescale 1ns / 1ps

module url_percent_encoder_tb;

    // Register addresses on the APB port.
    localparam logic [2:0] ADDR_KEEP_SLASH   = 3'h0;
    localparam logic [2:0] ADDR_OUTPUT_LIMIT = 3'h4;

    localparam int unsigned COUNT_MAX    = (1 << upe_pkg::COUNT_BITS_DEF) - 1;
    localparam int unsigned RUN_LIMIT    = 2000000;
    localparam int          DRAIN_CYCLES = 24;
    localparam int          LONG_BYTES   = 50;

    localparam string HEX_UPPER   = "0123456789ABCDEF";
    localparam string HEX_ANY     = "0123456789ABCDEFabcdef";
    localparam string PLAIN_CHARS = "ABMYZabmyz0189-._~";

    // One expected output byte with its side fields.
    typedef struct packed {
        logic [7:0]  data;
        logic        run_last;
        logic        str_last;
        logic        ovf;
        logic [15:0] len;
    } t_enc_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] in_byte
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;    // [7:0] out_byte, [23:8] total_length
    logic [1:0]  m_axis_tuser;    // [0] run_last, [1] overflow
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Encoder model state and register copies.
    t_enc_beat      enc_q[$];
    upe_pkg::t_look look_st;
    logic [7:0]     held_digit;
    int unsigned    enc_count;
    logic           ovf_st;
    logic           cfg_keep_slash;
    logic [15:0]    cfg_limit;

    int          tx_idle_pct;
    int          rx_idle_pct;
    int          fail_count;
    int unsigned cycle_count;
    t_enc_beat   want_beat;

    url_percent_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 4 ns clock.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Run limit in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic hex_digit_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
               (c >= "a" && c <= "f");
    endfunction

    function automatic logic unreserved_char(input logic [7:0] c);
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9"))
            return 1'b1;
        if (c == upe_pkg::CH_DASH || c == upe_pkg::CH_DOT || c == upe_pkg::CH_USCR ||
            c == upe_pkg::CH_TILDE)
            return 1'b1;
        return c == upe_pkg::CH_SLASH && cfg_keep_slash;
    endfunction

    // Emits one group of output bytes; the limit is checked once per group.
    function automatic void emit_group(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2, input int n);
        logic [7:0] grp [3];
        t_enc_beat  beat;
        int         i;
        grp[0] = b0;
        grp[1] = b1;
        grp[2] = b2;
        if (!ovf_st && cfg_limit != 0 && enc_count + n > cfg_limit)
            ovf_st = 1'b1;
        for (i = 0; i < n; i++) begin
            if (enc_count < COUNT_MAX)
                enc_count++;
            beat.data     = ovf_st ? 8'h00 : grp[i];
            beat.run_last = 1'b0;
            beat.str_last = 1'b0;
            beat.ovf      = ovf_st;
            beat.len      = enc_count[15:0];
            enc_q.push_back(beat);
        end
    endfunction

    function automatic void emit_literal(input logic [7:0] c);
        emit_group(c, 8'h00, 8'h00, 1);
    endfunction

    // Unreserved bytes pass; anything else becomes a percent triplet.
    function automatic void emit_encoded(input logic [7:0] c);
        if (unreserved_char(c))
            emit_literal(c);
        else
            emit_group(upe_pkg::CH_PCT, HEX_UPPER[(c >> 4) & upe_pkg::NIB_MASK],
                       HEX_UPPER[c & upe_pkg::NIB_MASK], 3);
    endfunction

    // A new byte with nothing pending: a percent sign opens a lookahead.
    function automatic void take_fresh(input logic [7:0] c, input logic last);
        if (c == upe_pkg::CH_PCT && !last)
            look_st = upe_pkg::LK_PCT;
        else
            emit_encoded(c);
    endfunction

    // Queues the output bytes that one accepted input byte causes.
    function automatic void predict_encoding(input logic [7:0] c, input logic last);
        int        first;
        t_enc_beat beat;
        first = enc_q.size();
        case (look_st)
            upe_pkg::LK_PCT: begin
                if (hex_digit_char(c) && !last) begin
                    held_digit = c;
                    look_st    = upe_pkg::LK_HEX;
                end else begin
                    look_st = upe_pkg::LK_NONE;
                    emit_encoded(upe_pkg::CH_PCT);
                    take_fresh(c, last);
                end
            end
            upe_pkg::LK_HEX: begin
                look_st = upe_pkg::LK_NONE;
                if (hex_digit_char(c)) begin
                    emit_literal(upe_pkg::CH_PCT);
                    emit_literal(held_digit);
                    emit_literal(c);
                end else begin
                    emit_encoded(upe_pkg::CH_PCT);
                    emit_encoded(held_digit);
                    take_fresh(c, last);
                end
            end
            default: begin
                look_st = upe_pkg::LK_NONE;
                take_fresh(c, last);
            end
        endcase
        if (enc_q.size() > first) begin
            beat          = enc_q.pop_back();
            beat.run_last = 1'b1;
            beat.str_last = last;
            enc_q.push_back(beat);
        end
        if (last) begin
            look_st   = upe_pkg::LK_NONE;
            enc_count = 0;
            ovf_st    = 1'b0;
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endfunction

    // Output checker: every output transaction is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (enc_q.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected output, expected none, actual data 0x%0h",
                         $time, m_axis_tdata);
            end else begin
                want_beat = enc_q.pop_front();
                check_field("out_byte", want_beat.data, m_axis_tdata[7:0]);
                check_field("total_length", want_beat.len, m_axis_tdata[23:8]);
                check_field("run_last", want_beat.run_last, m_axis_tuser[0]);
                check_field("overflow", want_beat.ovf, m_axis_tuser[1]);
                check_field("string_last", want_beat.str_last, m_axis_tlast);
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        m_axis_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end

    // Sends one input byte and returns at the edge that accepts it.
    task automatic send_byte(input logic [7:0] c, input logic last);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        predict_encoding(c, last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
    endtask

    task automatic send_text(input string s, input logic last_at_end);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], last_at_end && i == s.len() - 1);
    endtask

    // Stops sending and waits until every expected byte has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (enc_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write followed by a read back, done with the block idle.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        logic [31:0] want;
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        if (addr == ADDR_KEEP_SLASH) begin
            cfg_keep_slash = value[0];
            want           = {31'h0, value[0]};
        end else begin
            cfg_limit = value[15:0];
            want      = {16'h0, value[15:0]};
        end
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        check_field("register read", want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_idle(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    // Unreserved characters, the byte extremes, and slash in both modes.
    task automatic test_passthrough();
        write_reg(ADDR_KEEP_SLASH, 32'd1);
        write_reg(ADDR_OUTPUT_LIMIT, 32'd0);
        send_text("Za9-._~/", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        write_reg(ADDR_KEEP_SLASH, 32'd0);
        send_byte(upe_pkg::CH_SLASH, 1'b1);
    endtask

    // Existing escapes, broken escapes and lookahead cut short by the end of string.
    task automatic test_escapes();
        write_reg(ADDR_KEEP_SLASH, 32'd1);
        send_text("%2f", 1'b1);
        send_text("%G", 1'b1);
        send_text("%A", 1'b1);
        send_text("%", 1'b1);
        send_text("%4%41", 1'b1);
    endtask

    // Overflow on a plain byte, on an encoded group and inside a literal escape.
    task automatic test_output_limit();
        write_reg(ADDR_OUTPUT_LIMIT, 32'd3);
        send_text("a b", 1'b1);
        write_reg(ADDR_OUTPUT_LIMIT, 32'd1);
        send_text("%41", 1'b1);
    endtask

    function automatic logic [7:0] random_non_hex();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (hex_digit_char(c))
            c = 8'($urandom_range(255));
        return c;
    endfunction

    // One string built mostly from well-formed pieces, with broken escapes mixed in.
    task automatic send_random_string(output int n_sent);
        logic [7:0] str_q[$];
        int         len;
        int         i;
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
        while (str_q.size() < len) begin
            case ($urandom_range(9))
                0, 1, 2: str_q.push_back(PLAIN_CHARS[$urandom_range(PLAIN_CHARS.len() - 1)]);
                3, 4: str_q.push_back(8'($urandom_range(255)));
                5, 6: begin
                    str_q.push_back(upe_pkg::CH_PCT);
                    str_q.push_back(HEX_ANY[$urandom_range(HEX_ANY.len() - 1)]);
                    str_q.push_back(HEX_ANY[$urandom_range(HEX_ANY.len() - 1)]);
                end
                7: begin
                    str_q.push_back(upe_pkg::CH_PCT);
                    str_q.push_back(HEX_ANY[$urandom_range(HEX_ANY.len() - 1)]);
                    str_q.push_back(($urandom_range(1) == 0) ? upe_pkg::CH_PCT
                                                             : random_non_hex());
                end
                8: begin
                    str_q.push_back(upe_pkg::CH_PCT);
                    str_q.push_back(($urandom_range(1) == 0) ? upe_pkg::CH_PCT
                                                             : random_non_hex());
                end
                default: str_q.push_back(upe_pkg::CH_SLASH);
            endcase
        end
        for (i = 0; i < str_q.size(); i++)
            send_byte(str_q[i], i == str_q.size() - 1);
        n_sent = str_q.size();
    endtask

    // Random strings under changing register settings.
    task automatic test_random(input int n_items, input int tx_pct, input int rx_pct);
        int sent;
        int n;
        int strings;
        set_idle(tx_pct, rx_pct);
        sent    = 0;
        strings = 0;
        while (sent < n_items) begin
            if (strings % 8 == 0) begin
                write_reg(ADDR_KEEP_SLASH, $urandom_range(1));
                case ($urandom_range(4))
                    0: write_reg(ADDR_OUTPUT_LIMIT, 32'd0);
                    1: write_reg(ADDR_OUTPUT_LIMIT, $urandom_range(1, 4));
                    2, 3: write_reg(ADDR_OUTPUT_LIMIT, $urandom_range(5, 40));
                    default: write_reg(ADDR_OUTPUT_LIMIT, 32'd65535);
                endcase
            end
            send_random_string(n);
            sent += n;
            strings++;
        end
    endtask

    // One long string of encoded bytes that runs past a mid-size limit.
    task automatic test_long_string();
        int i;
        set_idle(0, 0);
        write_reg(ADDR_OUTPUT_LIMIT, 32'd100);
        for (i = 0; i < LONG_BYTES; i++)
            send_byte(8'hFF, 1'b0);
        send_byte("a", 1'b1);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= ADDR_KEEP_SLASH;
        pwdata        <= 32'h0;
        cycle_count    = 0;
        fail_count     = 0;
        look_st        = upe_pkg::LK_NONE;
        held_digit     = 8'h00;
        enc_count      = 0;
        ovf_st         = 1'b0;
        cfg_keep_slash = 1'b1;
        cfg_limit      = 16'h0;
        set_idle(6, 47);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_passthrough();
        test_escapes();
        test_output_limit();
        test_random(150, 6, 47);
        test_random(150, 47, 6);
        test_random(150, 0, 0);
        test_long_string();

        wait_drained();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: url_percent_encoder.f
+incdir+rtl/core
rtl/core/upe_pkg.sv
rtl/core/upe_front.sv
rtl/core/upe_queue.sv
rtl/core/upe_back.sv
rtl/core/url_percent_encoder.sv
sim/url_percent_encoder_tb.sv
